// ===== hw/rtl/wsfp_pkg.sv =====
// Shared types, constants and helpers for the WebSocket frame parser.
`default_nettype none
package wsfp_pkg;

	localparam int PAYLOAD_COUNT_BITS = 25;
	localparam int MAX_LEN_W          = 25;
	localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = MAX_LEN_W'(16777216);

	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;

	typedef enum logic [2:0] {
		PH_B0    = 3'd0,
		PH_B1    = 3'd1,
		PH_EXT16 = 3'd2,
		PH_EXT64 = 3'd3,
		PH_MASK  = 3'd4,
		PH_DATA  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_PING  = 2'd1,
		KIND_CLOSE = 2'd2,
		KIND_ERROR = 2'd3
	} frame_kind_t;

	typedef struct packed {
		logic        emits;
		frame_kind_t kind;
	} op_class_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        has_byte;
		frame_kind_t frame_kind;
		logic        frame_end;
	} result_t;

	function automatic op_class_t classify(input logic [3:0] op);
		op_class_t c;
		c.emits = 1'b1;
		c.kind  = KIND_DATA;
		if (op == OP_TEXT || op == OP_CONT) begin
			c.kind = KIND_DATA;
		end else if (op == OP_PING) begin
			c.kind = KIND_PING;
		end else if (op == OP_CLOSE) begin
			c.kind = KIND_CLOSE;
		end else begin
			c.emits = 1'b0;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/websocket_frame_parser.sv =====
// WebSocket receive-side frame parser: header decode, unmasking and result tagging.
//
//  Channel          Direction  Transaction                      Payload
//  s_axis           in         one received byte                tdata[7:0] = rx_byte
//  m_axis           out        one parser result                tdata = payload_byte,
//                                                              tuser = {frame_kind, has_byte},
//                                                              tlast = frame_end
//  max_payload_len  in         register write on _wr high       25-bit length cap
//
// Each byte is captured in an input register and, when the output slot has room, decoded
// against the parse state by one pass of shallow logic; any result lands in the output
// register. One byte per clock is sustained while m_axis is not stalled.
// A stall on m_axis holds the output register, the parse state and a full input register;
// it takes bytes while empty or while the output slot is free or emptied this cycle.
// Reset (arst_n low) clears the parse state to await a first header byte and sets the
// length cap to 16 MiB.
`default_nettype none
module websocket_frame_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Received byte stream. tdata: [7:0] rx_byte.
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,
	// Parser results. tdata: [7:0] payload_byte.
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [7:0]  m_axis_tdata,
	// tuser: [0] has_byte, [2:1] frame_kind.
	output      logic [2:0]  m_axis_tuser,
	output      logic        m_axis_tlast,
	// Length cap register write.
	input  wire logic        max_payload_len_wr,
	input  wire logic [wsfp_pkg::MAX_LEN_W-1:0] max_payload_len
);

	localparam int CW = wsfp_pkg::PAYLOAD_COUNT_BITS;
	// The length and the cap are compared at the wider of their two widths.
	localparam int CMP_W = (CW > wsfp_pkg::MAX_LEN_W) ? CW : wsfp_pkg::MAX_LEN_W;

	// Input register and output register.
	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               valid_s2;
	wsfp_pkg::result_t  res_s2;

	// Parse state.
	wsfp_pkg::phase_t   phase_q, phase_n;
	logic [3:0]         opcode_q, opcode_n;
	logic               mask_q, mask_n;
	logic [CW-1:0]      len_q, len_n;
	logic               len_hi_q, len_hi_n;   // a set bit was shifted out above the count
	logic [2:0]         hcnt_q, hcnt_n;
	logic [31:0]        key_q, key_n;
	logic [1:0]         lane_q, lane_n;
	logic [CW-1:0]      left_q, left_n;
	logic [wsfp_pkg::MAX_LEN_W-1:0] cap_q;

	logic               advance;
	logic               emit;
	wsfp_pkg::result_t  res_n;

	logic               len_done;
	logic [CW-1:0]      len_val;
	logic               len_big;
	logic               start;
	logic [CW-1:0]      start_cnt;
	logic [7:0]         key_byte;
	logic               last;
	wsfp_pkg::op_class_t cls;

	// The output slot is free or drains this cycle, so the captured byte can be decoded.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	assign cls = wsfp_pkg::classify(opcode_q);

	always_comb begin
		phase_n   = phase_q;
		opcode_n  = opcode_q;
		mask_n    = mask_q;
		len_n     = len_q;
		len_hi_n  = len_hi_q;
		hcnt_n    = hcnt_q;
		key_n     = key_q;
		lane_n    = lane_q;
		left_n    = left_q;
		emit      = 1'b0;
		res_n     = '{payload_byte: 8'h00, has_byte: 1'b0,
			frame_kind: wsfp_pkg::KIND_DATA, frame_end: 1'b0};
		len_done  = 1'b0;
		len_val   = '0;
		len_big   = 1'b0;
		start     = 1'b0;
		start_cnt = left_q;
		key_byte  = 8'h00;
		last      = 1'b0;

		unique case (phase_q)
			wsfp_pkg::PH_B1: begin
				mask_n   = byte_s1[7];
				hcnt_n   = 3'd0;
				len_n    = '0;
				len_hi_n = 1'b0;
				if (byte_s1[6:0] == wsfp_pkg::LEN7_EXT16) begin
					phase_n = wsfp_pkg::PH_EXT16;
				end else if (byte_s1[6:0] == wsfp_pkg::LEN7_EXT64) begin
					phase_n = wsfp_pkg::PH_EXT64;
				end else begin
					len_done = 1'b1;
					len_val  = CW'(byte_s1[6:0]);
					len_big  = 1'b0;
				end
			end
			wsfp_pkg::PH_EXT16, wsfp_pkg::PH_EXT64: begin
				// Big-endian: shift the running length up a byte.
				len_hi_n = len_hi_q | (|len_q[CW-1:CW-8]);
				len_n    = {len_q[CW-9:0], byte_s1};
				if (hcnt_q == ((phase_q == wsfp_pkg::PH_EXT16) ? 3'd1 : 3'd7)) begin
					len_done = 1'b1;
					len_val  = len_n;
					len_big  = len_hi_n;
				end else begin
					hcnt_n = hcnt_q + 3'd1;
				end
			end
			wsfp_pkg::PH_MASK: begin
				key_n = {key_q[23:0], byte_s1};
				if (hcnt_q == 3'd3) begin
					hcnt_n    = 3'd0;
					start     = 1'b1;
					start_cnt = left_q;
				end else begin
					hcnt_n = hcnt_q + 3'd1;
				end
			end
			wsfp_pkg::PH_DATA: begin
				unique case (lane_q)
					2'd0:    key_byte = key_q[31:24];
					2'd1:    key_byte = key_q[23:16];
					2'd2:    key_byte = key_q[15:8];
					default: key_byte = key_q[7:0];
				endcase
				lane_n = lane_q + 2'd1;
				if (left_q != '0) begin
					left_n = left_q - CW'(1);
				end
				last = (left_n == '0);
				if (last) begin
					phase_n = wsfp_pkg::PH_B0;
				end
				if (cls.emits && cls.kind != wsfp_pkg::KIND_CLOSE) begin
					emit               = 1'b1;
					res_n.payload_byte = byte_s1 ^ key_byte;
					res_n.has_byte     = 1'b1;
					res_n.frame_kind   = cls.kind;
					res_n.frame_end    = last;
				end else if (cls.emits && last) begin
					// A close frame reports once, on its final byte.
					emit             = 1'b1;
					res_n.frame_kind = wsfp_pkg::KIND_CLOSE;
					res_n.frame_end  = 1'b1;
				end
			end
			default: begin
				// First header byte; also recovers from any unused phase code.
				opcode_n = byte_s1[3:0];
				phase_n  = wsfp_pkg::PH_B1;
			end
		endcase

		// Length complete: check it against the cap before any mask key.
		if (len_done) begin
			hcnt_n = 3'd0;
			if (len_big || (CMP_W'(len_val) > CMP_W'(cap_q))) begin
				phase_n          = wsfp_pkg::PH_B0;
				emit             = 1'b1;
				res_n.frame_kind = wsfp_pkg::KIND_ERROR;
				res_n.frame_end  = 1'b1;
			end else begin
				left_n = len_val;
				key_n  = 32'h0;
				if (mask_n) begin
					phase_n = wsfp_pkg::PH_MASK;
				end else begin
					start     = 1'b1;
					start_cnt = len_val;
				end
			end
		end

		// Header finished: enter the payload, or close off an empty frame at once.
		if (start) begin
			lane_n = 2'd0;
			if (start_cnt != '0) begin
				phase_n = wsfp_pkg::PH_DATA;
			end else begin
				phase_n = wsfp_pkg::PH_B0;
				if (cls.emits) begin
					emit             = 1'b1;
					res_n.frame_kind = cls.kind;
					res_n.frame_end  = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			phase_q  <= wsfp_pkg::PH_B0;
			opcode_q <= 4'h0;
			mask_q   <= 1'b0;
			len_q    <= '0;
			len_hi_q <= 1'b0;
			hcnt_q   <= 3'd0;
			key_q    <= 32'h0;
			lane_q   <= 2'd0;
			left_q   <= '0;
			cap_q    <= wsfp_pkg::MAX_LEN_RESET;
		end else begin
			if (max_payload_len_wr) begin
				cap_q <= max_payload_len;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= emit;
				phase_q  <= phase_n;
				opcode_q <= opcode_n;
				mask_q   <= mask_n;
				len_q    <= len_n;
				len_hi_q <= len_hi_n;
				hcnt_q   <= hcnt_n;
				key_q    <= key_n;
				lane_q   <= lane_n;
				left_q   <= left_n;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
		if (advance && emit) begin
			res_s2 <= res_n;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = res_s2.payload_byte;
	assign m_axis_tuser  = {res_s2.frame_kind, res_s2.has_byte};
	assign m_axis_tlast  = res_s2.frame_end;

endmodule
`default_nettype wire
